// File: design/bmbs_pkg.sv
// ----------------------------------------------------------------------------
// bmbs_pkg: shared types and constants of the two-mode bandit selector
// Register indexes, decision path codes and the fixed square-root-of-two table.
// ----------------------------------------------------------------------------
package bmbs_pkg;

  typedef enum logic [1:0] {
    REG_SLOPE_THRESHOLD       = 2'd0,
    REG_BOREDOM_FACTOR        = 2'd1,
    REG_TEMPERATURE_NUMERATOR = 2'd2,
    REG_VOLATILITY_OFFSET     = 2'd3
  } cfg_reg_t;

  localparam logic [2:0] PATH_WARM_UNSAMPLED = 3'd0;
  localparam logic [2:0] PATH_WARM_ALTERNATE = 3'd1;
  localparam logic [2:0] PATH_KEEP           = 3'd2;
  localparam logic [2:0] PATH_SWITCH         = 3'd3;
  localparam logic [2:0] PATH_BOLTZMANN      = 3'd4;

  localparam logic [15:0] SLOPE_THRESHOLD_RST = 16'd16384;
  localparam logic [15:0] BOREDOM_FACTOR_RST  = 16'd55706;
  localparam logic [15:0] TEMP_NUM_RST        = 16'd32768;
  localparam logic [15:0] VOL_OFFSET_RST      = 16'd3277;

  localparam int          RING_DEPTH = 5;
  localparam logic [31:0] LOG2E_Q16  = 32'd94548;
  localparam logic [63:0] Z_MAX      = 64'd1310720;  // 20.0 in Q.16

  // root[k] = 2^(1/2^(k+1)) in Q2.30, built by the same truncating isqrt
  typedef logic [15:0][31:0] root_tab_t;

  function automatic root_tab_t root_table();
    root_tab_t   tab;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] b;
    r = 64'd2 << 30;
    for (int k = 0; k < 16; k++) begin
      x   = r << 30;
      res = '0;
      b   = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
        if (x >= res + b) begin
          x   = x - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      r      = res;
      tab[k] = r[31:0];
    end
    return tab;
  endfunction

endpackage

// File: design/bmbs_ifs.sv
// ----------------------------------------------------------------------------
// bmbs channel interfaces
// Restart item, selection result and configuration write channels.
// ----------------------------------------------------------------------------
interface bmbs_item_if;
  logic        valid;
  logic        ready;
  logic [31:0] decision_count;
  logic [31:0] conflict_count;
  logic [31:0] glue_average;
  logic [15:0] random_draw;

  modport source(output valid, decision_count, conflict_count, glue_average,
                 random_draw, input ready);
  modport sink(input valid, decision_count, conflict_count, glue_average,
               random_draw, output ready);
endinterface

interface bmbs_result_if;
  logic        valid;
  logic        ready;
  logic        next_mode;
  logic [21:0] phase_reward;
  logic [2:0]  decision_path;

  modport source(output valid, next_mode, phase_reward, decision_path, input ready);
  modport sink(input valid, next_mode, phase_reward, decision_path, output ready);
endinterface

interface bmbs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: design/boltzmann_mode_bandit_selector_core.sv
// Run time per restart is set mostly by the bit-serial divider (10 pair
//   quotients, two qualities, z and the sigmoid) and the 16 squarings of each
//   log2, and grows once the history ring is full.
// Throughput: one restart at a time; item.ready is high only while idle, and the
//   last cycle also waits while an earlier result has not been taken.
// Reset (rst, synchronous): history, sums, counts and mode clear, registers
//   return to their defaults, no result pending.
// ----------------------------------------------------------------------------
// boltzmann_mode_bandit_selector_core
// Sequencer around one shared multiplier, a restoring divider and an isqrt step.
// ----------------------------------------------------------------------------
module boltzmann_mode_bandit_selector_core (
  input  logic clk,
  input  logic rst,
  bmbs_item_if.sink     item,
  bmbs_result_if.source result,
  bmbs_cfg_if.sink      cfg
);

  localparam bmbs_pkg::root_tab_t ROOTS = bmbs_pkg::root_table();
  localparam int RING = bmbs_pkg::RING_DEPTH;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LOG_NORM, ST_LOG_MUL, ST_LOG_UPD, ST_LOG_DONE, ST_UPDATE,
    ST_SLOPE, ST_PAIR, ST_PAIR_MUL, ST_PAIR_ACC, ST_SQRT, ST_QUAL,
    ST_BORE_MUL, ST_BORE_UPD, ST_QNEXT, ST_ZSEL, ST_ZMUL, ST_ZDIV,
    ST_EXP_W, ST_EXP_SPLIT, ST_EXP_MUL, ST_EXP_UPD, ST_PS_START, ST_PICK,
    ST_FINISH, ST_DIV, ST_DIV_DONE
  } state_t;

  typedef enum logic [2:0] {
    DOP_REWARD, DOP_PAIR, DOP_QUAL, DOP_Z, DOP_PS
  } div_op_t;

  state_t  state;
  div_op_t dop;

  logic [15:0] slope_threshold, boredom_factor, temperature_numerator, volatility_offset;

  logic [31:0] cur_c, cur_g;
  logic [15:0] cur_draw;

  logic [31:0] ly;
  logic [4:0]  ln;
  logic [15:0] lfrac;
  logic [3:0]  lk;
  logic        lsel;
  logic [20:0] ld;
  logic [21:0] reward;

  logic [31:0] ghist [RING];
  logic [31:0] chist [RING];
  logic [2:0]  fill_count;
  logic        active_mode;
  logic [53:0] rsum0, rsum1;
  logic [31:0] pick0, pick1;
  logic        nxt;
  logic [2:0]  path;

  logic [34:0] sum_c;
  logic [31:0] wk [RING];
  logic        ph;
  logic [2:0]  rot;
  logic [35:0] v2;
  logic [31:0] qtmp;
  logic [35:0] sx, sres, sbit;
  logic [4:0]  scnt;
  logic [18:0] vol;

  logic        qsel;
  logic [31:0] q0, q1, diff;
  logic        one_better;
  logic [20:0] z;
  logic        zbig;
  logic [4:0]  ip;
  logic [15:0] fp;
  logic [31:0] acc;
  logic [3:0]  ek;
  logic [16:0] ps;

  logic [63:0] rem, quo, dvd, dvs;
  logic [5:0]  dcnt;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  logic        res_valid, res_mode;
  logic [21:0] res_reward;
  logic [2:0]  res_path;

  // combinational helpers
  logic [32:0] y2;
  logic [63:0] div_r2;
  logic [35:0] sq_s;
  logic [35:0] slope_pos, slope_neg, slope_lim;
  logic [34:0] csum;
  logic [31:0] pair_b, pair_df;
  logic [54:0] rsum_ext;
  logic [53:0] rsum_sat;
  logic [16:0] p0;
  logic [31:0] d_in, c_in;

  assign item.ready          = (state == ST_IDLE);
  assign cfg.ready           = 1'b1;
  assign result.valid        = res_valid;
  assign result.next_mode    = res_mode;
  assign result.phase_reward = res_reward;
  assign result.decision_path = res_path;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_LOG_MUL:  begin mul_a = ly;            mul_b = ly; end
      ST_PAIR_MUL: begin mul_a = qtmp;          mul_b = qtmp; end
      ST_BORE_MUL: begin mul_a = qtmp;          mul_b = {16'd0, boredom_factor}; end
      ST_ZMUL:     begin mul_a = diff;
                         mul_b = 32'(vol) + 32'(volatility_offset); end
      ST_EXP_W:    begin mul_a = 32'(z);        mul_b = bmbs_pkg::LOG2E_Q16; end
      ST_EXP_MUL:  begin mul_a = acc;           mul_b = ROOTS[ek]; end
      default:     begin mul_a = '0;            mul_b = '0; end
    endcase
  end

  always_comb begin
    d_in      = (item.decision_count == 32'd0) ? 32'd1 : item.decision_count;
    c_in      = (item.conflict_count == 32'd0) ? 32'd1 : item.conflict_count;
    y2        = prod[63:31];
    div_r2    = {rem[62:0], dvd[dcnt]};
    sq_s      = sres + sbit;
    slope_pos = (36'(ghist[4]) << 1) + 36'(ghist[3]);
    slope_neg = (36'(ghist[0]) << 1) + 36'(ghist[1]);
    slope_lim = (36'(slope_threshold) << 3) + (36'(slope_threshold) << 1);
    csum      = 35'(chist[0]) + 35'(chist[1]) + 35'(chist[2]) + 35'(chist[3])
              + 35'(chist[4]);
    pair_b    = ph ? wk[2] : wk[1];
    pair_df   = (wk[0] > pair_b) ? wk[0] - pair_b : pair_b - wk[0];
    rsum_ext  = active_mode ? 55'(rsum1) + 55'(reward) : 55'(rsum0) + 55'(reward);
    rsum_sat  = rsum_ext[54] ? '1 : rsum_ext[53:0];
    p0        = one_better ? ps : 17'd65536 - ps;
  end

  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
    if (rst) begin
      state                 <= ST_IDLE;
      dop                   <= DOP_REWARD;
      slope_threshold       <= bmbs_pkg::SLOPE_THRESHOLD_RST;
      boredom_factor        <= bmbs_pkg::BOREDOM_FACTOR_RST;
      temperature_numerator <= bmbs_pkg::TEMP_NUM_RST;
      volatility_offset     <= bmbs_pkg::VOL_OFFSET_RST;
      for (int i = 0; i < RING; i++) begin
        ghist[i] <= '0;
        chist[i] <= '0;
      end
      fill_count  <= '0;
      active_mode <= 1'b0;
      rsum0       <= '0;
      rsum1       <= '0;
      pick0       <= '0;
      pick1       <= '0;
      res_valid   <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          bmbs_pkg::REG_SLOPE_THRESHOLD:       slope_threshold       <= cfg.data;
          bmbs_pkg::REG_BOREDOM_FACTOR:        boredom_factor        <= cfg.data;
          bmbs_pkg::REG_TEMPERATURE_NUMERATOR: temperature_numerator <= cfg.data;
          bmbs_pkg::REG_VOLATILITY_OFFSET:     volatility_offset     <= cfg.data;
          default: ;
        endcase
      end
      // ST_FINISH reloads the result register itself
      if (res_valid && result.ready && state != ST_FINISH) res_valid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (item.valid) begin
            cur_c    <= c_in;
            cur_g    <= item.glue_average;
            cur_draw <= item.random_draw;
            ly       <= d_in;
            ln       <= 5'd31;
            lfrac    <= '0;
            lk       <= '0;
            lsel     <= 1'b0;
            state    <= ST_LOG_NORM;
          end
        end
        ST_LOG_NORM: begin
          if (ly[31]) begin
            state <= ST_LOG_MUL;
          end else begin
            ly <= ly << 1;
            ln <= ln - 5'd1;
          end
        end
        ST_LOG_MUL: state <= ST_LOG_UPD;
        ST_LOG_UPD: begin
          lfrac <= {lfrac[14:0], y2[32]};
          ly    <= y2[32] ? y2[32:1] : y2[31:0];
          lk    <= lk + 4'd1;
          state <= (lk == 4'd15) ? ST_LOG_DONE : ST_LOG_MUL;
        end
        ST_LOG_DONE: begin
          if (!lsel) begin
            ld <= {ln, lfrac};
            if (cur_c > 32'd1) begin
              lsel  <= 1'b1;
              ly    <= cur_c;
              ln    <= 5'd31;
              lfrac <= '0;
              lk    <= '0;
              state <= ST_LOG_NORM;
            end else begin
              reward <= 22'({ln, lfrac});
              state  <= ST_UPDATE;
            end
          end else begin
            rem   <= '0;
            quo   <= '0;
            dvd   <= 64'(ld) << 16;
            dvs   <= 64'({ln, lfrac});
            dcnt  <= 6'd37;
            dop   <= DOP_REWARD;
            state <= ST_DIV;
          end
        end
        ST_UPDATE: begin
          if (active_mode) rsum1 <= rsum_sat;
          else rsum0 <= rsum_sat;
          for (int i = 0; i < RING - 1; i++) begin
            ghist[i] <= ghist[i+1];
            chist[i] <= chist[i+1];
          end
          ghist[RING-1] <= cur_g;
          chist[RING-1] <= cur_c;
          if (fill_count < 3'(RING)) fill_count <= fill_count + 3'd1;
          if (fill_count >= 3'(RING - 1)) begin
            state <= ST_SLOPE;
          end else begin
            if (pick0 == 32'd0) begin
              nxt  <= 1'b0;
              path <= bmbs_pkg::PATH_WARM_UNSAMPLED;
            end else if (pick1 == 32'd0) begin
              nxt  <= 1'b1;
              path <= bmbs_pkg::PATH_WARM_UNSAMPLED;
            end else begin
              nxt  <= ~active_mode;
              path <= bmbs_pkg::PATH_WARM_ALTERNATE;
            end
            state <= ST_FINISH;
          end
        end
        ST_SLOPE: begin
          sum_c <= csum;
          for (int i = 0; i < RING; i++) wk[i] <= chist[i];
          ph  <= 1'b0;
          rot <= '0;
          v2  <= '0;
          if (slope_pos + slope_lim < slope_neg) begin
            nxt   <= active_mode;
            path  <= bmbs_pkg::PATH_KEEP;
            state <= ST_FINISH;
          end else if (slope_pos > slope_neg + slope_lim) begin
            nxt   <= ~active_mode;
            path  <= bmbs_pkg::PATH_SWITCH;
            state <= ST_FINISH;
          end else if (csum == 35'd0) begin
            sx    <= '0;
            sres  <= '0;
            sbit  <= 36'd1 << 34;
            scnt  <= 5'd17;
            state <= ST_SQRT;
          end else begin
            state <= ST_PAIR;
          end
        end
        // all ten pairs: distance one and two around the rotating ring
        ST_PAIR: begin
          rem   <= '0;
          quo   <= '0;
          dvd   <= 64'(pair_df) << 16;
          dvs   <= 64'(sum_c);
          dcnt  <= 6'd47;
          dop   <= DOP_PAIR;
          state <= ST_DIV;
        end
        ST_PAIR_MUL: state <= ST_PAIR_ACC;
        ST_PAIR_ACC: begin
          v2 <= v2 + prod[35:0];
          if (!ph) begin
            ph    <= 1'b1;
            state <= ST_PAIR;
          end else begin
            ph <= 1'b0;
            for (int i = 0; i < RING - 1; i++) wk[i] <= wk[i+1];
            wk[RING-1] <= wk[0];
            if (rot == 3'(RING - 1)) begin
              sx    <= v2 + prod[35:0];
              sres  <= '0;
              sbit  <= 36'd1 << 34;
              scnt  <= 5'd17;
              state <= ST_SQRT;
            end else begin
              rot   <= rot + 3'd1;
              state <= ST_PAIR;
            end
          end
        end
        ST_SQRT: begin
          if (sx >= sq_s) begin
            sx   <= sx - sq_s;
            sres <= (sres >> 1) + sbit;
          end else begin
            sres <= sres >> 1;
          end
          sbit <= sbit >> 2;
          scnt <= scnt - 5'd1;
          if (scnt == 5'd0) begin
            vol   <= (sx >= sq_s) ? 19'((sres >> 1) + sbit) : 19'(sres >> 1);
            qsel  <= 1'b0;
            state <= ST_QUAL;
          end
        end
        ST_QUAL: begin
          if ((qsel ? pick1 : pick0) == 32'd0) begin
            if (qsel) q1 <= '0;
            else q0 <= '0;
            state <= ST_QNEXT;
          end else begin
            rem   <= '0;
            quo   <= '0;
            dvd   <= qsel ? 64'(rsum1) : 64'(rsum0);
            dvs   <= qsel ? 64'(pick1) : 64'(pick0);
            dcnt  <= 6'd53;
            dop   <= DOP_QUAL;
            state <= ST_DIV;
          end
        end
        ST_BORE_MUL: state <= ST_BORE_UPD;
        ST_BORE_UPD: begin
          if (qsel) q1 <= prod[47:16];
          else q0 <= prod[47:16];
          state <= ST_QNEXT;
        end
        ST_QNEXT: begin
          if (qsel) begin
            state <= ST_ZSEL;
          end else begin
            qsel  <= 1'b1;
            state <= ST_QUAL;
          end
        end
        ST_ZSEL: begin
          one_better <= (q1 >= q0);
          diff       <= (q1 >= q0) ? q1 - q0 : q0 - q1;
          if (q1 == q0) begin
            z     <= '0;
            zbig  <= 1'b0;
            state <= ST_EXP_W;
          end else if (temperature_numerator == 16'd0) begin
            zbig  <= 1'b1;
            state <= ST_EXP_W;
          end else begin
            state <= ST_ZMUL;
          end
        end
        ST_ZMUL: state <= ST_ZDIV;
        ST_ZDIV: begin
          rem   <= '0;
          quo   <= '0;
          dvd   <= prod;
          dvs   <= 64'(temperature_numerator);
          dcnt  <= 6'd50;
          dop   <= DOP_Z;
          state <= ST_DIV;
        end
        ST_EXP_W: begin
          if (zbig) begin
            ps    <= '0;
            state <= ST_PICK;
          end else begin
            state <= ST_EXP_SPLIT;
          end
        end
        ST_EXP_SPLIT: begin
          ip    <= prod[36:32];
          fp    <= prod[31:16];
          acc   <= 32'd1 << 30;
          ek    <= '0;
          state <= ST_EXP_MUL;
        end
        ST_EXP_MUL: state <= ST_EXP_UPD;
        ST_EXP_UPD: begin
          if (fp[4'd15 - ek]) acc <= prod[61:30];
          ek    <= ek + 4'd1;
          state <= (ek == 4'd15) ? ST_PS_START : ST_EXP_MUL;
        end
        ST_PS_START: begin
          rem   <= '0;
          quo   <= '0;
          dvd   <= 64'd1 << 46;
          dvs   <= (64'd1 << 30) + (64'(acc) << ip);
          dcnt  <= 6'd46;
          dop   <= DOP_PS;
          state <= ST_DIV;
        end
        ST_PICK: begin
          nxt   <= (17'(cur_draw) < p0) ? 1'b0 : 1'b1;
          path  <= bmbs_pkg::PATH_BOLTZMANN;
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!res_valid || result.ready) begin
            active_mode <= nxt;
            if (nxt) begin
              if (pick1 != '1) pick1 <= pick1 + 32'd1;
            end else begin
              if (pick0 != '1) pick0 <= pick0 + 32'd1;
            end
            res_valid  <= 1'b1;
            res_mode   <= nxt;
            res_reward <= reward;
            res_path   <= path;
            state      <= ST_IDLE;
          end
        end
        // restoring divider, one quotient bit per cycle
        ST_DIV: begin
          if (div_r2 >= dvs) begin
            rem <= div_r2 - dvs;
            quo <= {quo[62:0], 1'b1};
          end else begin
            rem <= div_r2;
            quo <= {quo[62:0], 1'b0};
          end
          dcnt <= dcnt - 6'd1;
          if (dcnt == 6'd0) state <= ST_DIV_DONE;
        end
        ST_DIV_DONE: begin
          case (dop)
            DOP_REWARD: begin
              reward <= quo[21:0];
              state  <= ST_UPDATE;
            end
            DOP_PAIR: begin
              qtmp  <= quo[31:0];
              state <= ST_PAIR_MUL;
            end
            DOP_QUAL: begin
              if (qsel == active_mode) begin
                qtmp  <= (|quo[63:32]) ? '1 : quo[31:0];
                state <= ST_BORE_MUL;
              end else begin
                if (qsel) q1 <= (|quo[63:32]) ? '1 : quo[31:0];
                else q0 <= (|quo[63:32]) ? '1 : quo[31:0];
                state <= ST_QNEXT;
              end
            end
            DOP_Z: begin
              zbig  <= (quo > bmbs_pkg::Z_MAX);
              z     <= quo[20:0];
              state <= ST_EXP_W;
            end
            DOP_PS: begin
              ps    <= quo[16:0];
              state <= ST_PICK;
            end
            default: state <= ST_IDLE;
          endcase
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> !item.ready)
    else $error("selector ready right after an accepted item");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= 3'(RING))
    else $error("history fill count out of range");
  a_path_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_path <= bmbs_pkg::PATH_BOLTZMANN)
    else $error("bad decision path code");
  a_reward_bound: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_reward <= 22'd2097152)
    else $error("phase reward out of range");
  a_mode_commit: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINISH && (!res_valid || result.ready) |=> active_mode == res_mode)
    else $error("active mode differs from reported mode");
`endif

endmodule

// File: sim/bmbs_checker.sv
// ----------------------------------------------------------------------------
// bmbs_checker: scoreboard for the two-mode bandit selector
// Watches the item, result and configuration channels, predicts each result
// from its own copy of the selector state and compares in order.
// ----------------------------------------------------------------------------
module bmbs_checker (
  input  logic clk,
  input  logic rst,
  bmbs_item_if.sink     item_mon,
  bmbs_result_if.sink   result_mon,
  bmbs_cfg_if.sink      cfg_mon,
  output int            error_count,
  output int            selections_pending
);

  typedef struct packed {
    logic        mode;
    logic [21:0] reward;
    logic [2:0]  path;
  } selection_t;

  selection_t  expected_selections[$];

  logic [31:0] glue_ring [bmbs_pkg::RING_DEPTH];
  logic [31:0] conflict_ring [bmbs_pkg::RING_DEPTH];
  int unsigned ring_slot;
  int unsigned ring_fill;
  logic        cur_mode;
  logic [63:0] mode_reward_sum [2];
  logic [31:0] mode_picks [2];
  logic [15:0] slope_thr;
  logic [15:0] boredom;
  logic [15:0] temp_num;
  logic [15:0] vol_offset;

  assign selections_pending = expected_selections.size();

  function automatic logic [63:0] log2_fix(logic [63:0] x);
    int unsigned n;
    logic [63:0] y;
    logic [63:0] frac;
    n = 0;
    frac = 0;
    if (x == 0) return 0;
    while (n < 31 && (x >> (n + 1)) != 0) n++;
    y = x << (31 - n);
    for (int k = 0; k < 16; k++) begin
      y = (y * y) >> 31;
      frac = frac << 1;
      if (y >= (64'd1 << 32)) begin
        frac[0] = 1'b1;
        y = y >> 1;
      end
    end
    return (64'(n) << 16) | frac;
  endfunction

  function automatic logic [63:0] sqrt_floor(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // 65536 / (1 + e^z), z and result in Q.16
  function automatic logic [63:0] sigmoid_tail(logic [63:0] z);
    logic [63:0] w;
    logic [63:0] ip;
    logic [63:0] fp;
    logic [63:0] acc;
    logic [63:0] root;
    if (z > (64'd20 << 16)) return 0;
    w = (z * 64'd94548) >> 16;
    ip = w >> 16;
    fp = w & 64'hFFFF;
    acc = 64'd1 << 30;
    root = 64'd2 << 30;
    for (int k = 1; k <= 16; k++) begin
      root = sqrt_floor(root << 30);
      if ((fp >> (16 - k)) & 1) acc = (acc * root) >> 30;
    end
    return (64'd1 << 46) / ((64'd1 << 30) + (acc << ip));
  endfunction

  function automatic logic [63:0] mode_quality(int h);
    logic [63:0] q;
    if (mode_picks[h] == 0) return 0;
    q = mode_reward_sum[h] / mode_picks[h];
    if (q > 64'hFFFFFFFF) q = 64'hFFFFFFFF;
    if (h == cur_mode) q = (q * boredom) >> 16;
    return q;
  endfunction

  task automatic predict_selection(logic [31:0] dec_in, logic [31:0] con_in,
                                   logic [31:0] glue, logic [15:0] draw);
    logic [63:0] d;
    logic [63:0] c;
    logic [63:0] ld;
    logic [63:0] reward;
    logic        nxt;
    logic [2:0]  path;
    longint      num;
    longint      lim;
    logic [63:0] cs [bmbs_pkg::RING_DEPTH];
    logic [63:0] sum_c;
    logic [63:0] v2;
    logic [63:0] vol;
    logic [63:0] q0;
    logic [63:0] q1;
    logic [63:0] diff;
    logic [63:0] z;
    logic [63:0] ps;
    logic [63:0] p0;
    logic [63:0] df;
    logic [63:0] qq;
    int unsigned pos;
    selection_t  sel;
    d = (dec_in == 0) ? 64'd1 : 64'(dec_in);
    c = (con_in == 0) ? 64'd1 : 64'(con_in);
    ld = log2_fix(d);
    reward = (c > 1) ? ((ld << 16) / log2_fix(c)) : ld;
    mode_reward_sum[cur_mode] = mode_reward_sum[cur_mode] + reward;
    if (mode_reward_sum[cur_mode] > ((64'd1 << 54) - 1))
      mode_reward_sum[cur_mode] = (64'd1 << 54) - 1;
    glue_ring[ring_slot] = glue;
    conflict_ring[ring_slot] = c[31:0];
    ring_slot = (ring_slot + 1 >= bmbs_pkg::RING_DEPTH) ? 0 : ring_slot + 1;
    if (ring_fill < bmbs_pkg::RING_DEPTH) ring_fill++;
    if (ring_fill >= bmbs_pkg::RING_DEPTH) begin
      num = 0;
      sum_c = 0;
      v2 = 0;
      lim = longint'(slope_thr) * 10;
      for (int i = 0; i < bmbs_pkg::RING_DEPTH; i++) begin
        pos = (ring_slot + i) % bmbs_pkg::RING_DEPTH;
        num += longint'(i - 2) * longint'({32'd0, glue_ring[pos]});
        cs[i] = 64'(conflict_ring[pos]);
        sum_c += cs[i];
      end
      if (num < -lim) begin
        nxt = cur_mode;
        path = bmbs_pkg::PATH_KEEP;
      end else if (num > lim) begin
        nxt = ~cur_mode;
        path = bmbs_pkg::PATH_SWITCH;
      end else begin
        for (int i = 0; i < bmbs_pkg::RING_DEPTH; i++)
          for (int j = i + 1; j < bmbs_pkg::RING_DEPTH; j++) begin
            df = (cs[i] > cs[j]) ? cs[i] - cs[j] : cs[j] - cs[i];
            qq = (df << 16) / sum_c;
            v2 += qq * qq;
          end
        vol = sqrt_floor(v2);
        q0 = mode_quality(0);
        q1 = mode_quality(1);
        diff = (q1 >= q0) ? q1 - q0 : q0 - q1;
        if (diff == 0) z = 0;
        else if (temp_num == 0) z = 64'd21 << 16;
        else z = diff * (vol + vol_offset) / temp_num;
        ps = sigmoid_tail(z);
        p0 = (q1 >= q0) ? ps : 64'd65536 - ps;
        nxt = (64'(draw) < p0) ? 1'b0 : 1'b1;
        path = bmbs_pkg::PATH_BOLTZMANN;
      end
    end else if (mode_picks[0] == 0) begin
      nxt = 1'b0;
      path = bmbs_pkg::PATH_WARM_UNSAMPLED;
    end else if (mode_picks[1] == 0) begin
      nxt = 1'b1;
      path = bmbs_pkg::PATH_WARM_UNSAMPLED;
    end else begin
      nxt = ~cur_mode;
      path = bmbs_pkg::PATH_WARM_ALTERNATE;
    end
    cur_mode = nxt;
    if (mode_picks[nxt] != 32'hFFFFFFFF) mode_picks[nxt]++;
    sel.mode = nxt;
    sel.reward = reward[21:0];
    sel.path = path;
    expected_selections.push_back(sel);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    error_count++;
  endtask

  initial error_count = 0;

  always @(posedge clk) begin
    selection_t want;
    if (rst) begin
      for (int i = 0; i < bmbs_pkg::RING_DEPTH; i++) begin
        glue_ring[i] = 0;
        conflict_ring[i] = 0;
      end
      ring_slot = 0;
      ring_fill = 0;
      cur_mode = 0;
      mode_reward_sum[0] = 0;
      mode_reward_sum[1] = 0;
      mode_picks[0] = 0;
      mode_picks[1] = 0;
      slope_thr = bmbs_pkg::SLOPE_THRESHOLD_RST;
      boredom = bmbs_pkg::BOREDOM_FACTOR_RST;
      temp_num = bmbs_pkg::TEMP_NUM_RST;
      vol_offset = bmbs_pkg::VOL_OFFSET_RST;
      expected_selections.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (bmbs_pkg::cfg_reg_t'(cfg_mon.index))
          bmbs_pkg::REG_SLOPE_THRESHOLD:       slope_thr = cfg_mon.data;
          bmbs_pkg::REG_BOREDOM_FACTOR:        boredom = cfg_mon.data;
          bmbs_pkg::REG_TEMPERATURE_NUMERATOR: temp_num = cfg_mon.data;
          bmbs_pkg::REG_VOLATILITY_OFFSET:     vol_offset = cfg_mon.data;
          default: ;
        endcase
      end
      if (result_mon.valid && result_mon.ready) begin
        if (expected_selections.size() == 0) begin
          report_mismatch("unexpected result transfer", 1, 0);
        end else begin
          want = expected_selections.pop_front();
          if (result_mon.next_mode !== want.mode)
            report_mismatch("next_mode", result_mon.next_mode, want.mode);
          if (result_mon.phase_reward !== want.reward)
            report_mismatch("phase_reward", result_mon.phase_reward, want.reward);
          if (result_mon.decision_path !== want.path)
            report_mismatch("decision_path", result_mon.decision_path, want.path);
        end
      end
      if (item_mon.valid && item_mon.ready)
        predict_selection(item_mon.decision_count, item_mon.conflict_count,
                          item_mon.glue_average, item_mon.random_draw);
    end
  end

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: regression bench for the two-mode bandit selector
// Drives directed and random restarts through several register settings, with
// random idling on both sides in some of them; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_top;

  logic clk;
  logic rst;
  int   error_count;
  int   selections_pending;
  int   send_idle_pct;
  int   recv_idle_pct;

  bmbs_item_if   item ();
  bmbs_result_if result ();
  bmbs_cfg_if    cfg ();

  boltzmann_mode_bandit_selector_core uut (
    .clk(clk), .rst(rst), .item(item.sink), .result(result.source), .cfg(cfg.sink)
  );

  bmbs_checker scoreboard (
    .clk(clk), .rst(rst), .item_mon(item.sink), .result_mon(result.sink),
    .cfg_mon(cfg.sink), .error_count(error_count),
    .selections_pending(selections_pending)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // receiver stall
  always @(posedge clk) begin
    if (rst) result.ready <= 1'b0;
    else result.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // valid stays up after a transfer until the next item or an idle cycle
  task automatic send_restart(logic [31:0] dec, logic [31:0] con, logic [31:0] glue,
                              logic [15:0] draw);
    while ($urandom_range(99) < send_idle_pct) begin
      item.valid <= 1'b0;
      @(posedge clk);
    end
    item.valid <= 1'b1;
    item.decision_count <= dec;
    item.conflict_count <= con;
    item.glue_average <= glue;
    item.random_draw <= draw;
    do @(posedge clk); while (!item.ready);
  endtask

  task automatic write_reg(bmbs_pkg::cfg_reg_t idx, logic [15:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_selections();
    item.valid <= 1'b0;
    while (selections_pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_count();
    case ($urandom_range(3))
      0: return $urandom_range(3);
      1: return $urandom_range(5000);
      2: return $urandom;
      default: return 32'hFFFF_FFFF - $urandom_range(2);
    endcase
  endfunction

  // glue trend: gentle drift, steep ramps up or down, or random values, picked anew every 20 restarts
  task automatic random_restarts(int n);
    logic [31:0] glue;
    int          trend;
    glue = $urandom_range(32'h0008_0000);
    for (int i = 0; i < n; i++) begin
      if (i % 20 == 0) trend = $urandom_range(3);
      case (trend)
        0: glue = glue + $urandom_range(300) - 150;
        1: glue = glue + $urandom_range(40000);
        2: glue = glue - $urandom_range(40000);
        default: glue = $urandom;
      endcase
      send_restart(rand_count(), rand_count(), glue, 16'($urandom_range(65535)));
    end
  endtask

  initial begin
    #20000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst = 1'b1;
    item.valid = 1'b0;
    item.decision_count = '0;
    item.conflict_count = '0;
    item.glue_average = '0;
    item.random_draw = '0;
    cfg.valid = 1'b0;
    cfg.index = bmbs_pkg::REG_SLOPE_THRESHOLD;
    cfg.data = '0;
    send_idle_pct = 6;
    recv_idle_pct = 59;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero counts, extremes, flat/steep glue, equal qualities
    send_restart(0, 0, 0, 0);
    send_restart(32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 16'hFFFF);
    send_restart(1, 32'hFFFF_FFFF, 0, 0);
    send_restart(32'hFFFF_FFFF, 2, 0, 16'h8000);
    send_restart(1000, 10, 0, 16'h7FFF);
    send_restart(1000, 10, 0, 16'h1234);
    for (int i = 0; i < 5; i++) send_restart(500, 20, 32'd10000 * i, 16'hFFFF);
    for (int i = 0; i < 5; i++) send_restart(500, 20, 32'hF000_0000 - i * 32'h100_0000, 0);
    for (int i = 0; i < 5; i++) send_restart(300 + i, 7 * i, 32'h0001_0000, 16'($urandom));
    drain_selections();

    write_reg(bmbs_pkg::REG_TEMPERATURE_NUMERATOR, 16'd0);
    write_reg(bmbs_pkg::REG_VOLATILITY_OFFSET, 16'd0);
    write_reg(bmbs_pkg::REG_SLOPE_THRESHOLD, 16'hFFFF);
    write_reg(bmbs_pkg::REG_BOREDOM_FACTOR, 16'hFFFF);
    for (int i = 0; i < 6; i++) send_restart(64, 1, 32'h0002_0000, 16'($urandom));
    random_restarts(200);
    drain_selections();

    send_idle_pct = 59;
    recv_idle_pct = 6;
    write_reg(bmbs_pkg::REG_TEMPERATURE_NUMERATOR, 16'hFFFF);
    write_reg(bmbs_pkg::REG_VOLATILITY_OFFSET, 16'd1);
    write_reg(bmbs_pkg::REG_SLOPE_THRESHOLD, 16'd0);
    write_reg(bmbs_pkg::REG_BOREDOM_FACTOR, 16'd0);
    random_restarts(250);
    drain_selections();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(bmbs_pkg::REG_TEMPERATURE_NUMERATOR, 16'd32768);
    write_reg(bmbs_pkg::REG_VOLATILITY_OFFSET, 16'hFFFF);
    write_reg(bmbs_pkg::REG_SLOPE_THRESHOLD, 16'd16384);
    write_reg(bmbs_pkg::REG_BOREDOM_FACTOR, 16'd55706);
    random_restarts(250);
    drain_selections();

    write_reg(bmbs_pkg::REG_TEMPERATURE_NUMERATOR, 16'($urandom));
    write_reg(bmbs_pkg::REG_VOLATILITY_OFFSET, 16'($urandom_range(65535, 1)));
    write_reg(bmbs_pkg::REG_SLOPE_THRESHOLD, 16'($urandom_range(4096)));
    write_reg(bmbs_pkg::REG_BOREDOM_FACTOR, 16'($urandom));
    random_restarts(250);
    drain_selections();

    if (error_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: filelist.f
design/bmbs_pkg.sv
design/bmbs_ifs.sv
design/boltzmann_mode_bandit_selector_core.sv
sim/bmbs_checker.sv
sim/tb_top.sv
